>>> hw/rtl/hba_pkg.sv
// shared types and constants for the hierarchical binning accumulator
// no dependencies; used by hba_level_store, hba_update_unit and the top level
package hba_pkg;

    // default number of binning levels
    localparam int LEVELS_DEFAULT = 16;

    // field widths
    localparam int CNT_W    = 32;
    localparam int SUM_W    = 48;
    localparam int SQ_W     = 63;
    localparam int SMP_W    = 16;
    localparam int LVL_IN_W = 4;
    localparam int DEPTH_W  = 5;

    // saturation limits
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [SQ_W-1:0]  SQ_MAX  = {SQ_W{1'b1}};

    // item opcodes
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // statistics and held sample of one level
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [SUM_W-1:0] sum;
        logic [SQ_W-1:0]  sq;
        logic [SMP_W-1:0] held;
        logic             held_valid;
    } hba_level_t;

    // write enables for the level store
    typedef struct packed {
        logic stats_we;
        logic sq_we;
        logic held_we;
    } hba_wr_ctl_t;

endpackage

>>> hw/rtl/hba_level_store.sv
// per-level statistics store: one shared address, registered read, field write enables
// depends on hba_pkg
module hba_level_store #(
    parameter int LEVELS = hba_pkg::LEVELS_DEFAULT,
    parameter int LVW    = (LEVELS > 1) ? $clog2(LEVELS) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [LVW-1:0]      addr,
    input  hba_pkg::hba_wr_ctl_t wr_ctl,
    input  hba_pkg::hba_level_t wdata,
    output hba_pkg::hba_level_t rdata
);

    hba_pkg::hba_level_t entry_reg [LEVELS];
    hba_pkg::hba_level_t rdata_reg;

    // level entries, all cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                entry_reg[i] <= '0;
            end
        end
        else
        begin
            if (wr_ctl.stats_we)
            begin
                entry_reg[addr].count <= wdata.count;
                entry_reg[addr].sum   <= wdata.sum;
            end
            if (wr_ctl.sq_we)
            begin
                entry_reg[addr].sq <= wdata.sq;
            end
            if (wr_ctl.held_we)
            begin
                entry_reg[addr].held       <= wdata.held;
                entry_reg[addr].held_valid <= wdata.held_valid;
            end
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= entry_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/hba_update_unit.sv
// shared arithmetic unit: registered square, saturating count/sum/square updates, half-sum
// depends on hba_pkg
module hba_update_unit (
    input  logic                       clk,
    input  logic                       sq_load,
    input  logic [hba_pkg::SMP_W-1:0]  value,
    input  hba_pkg::hba_level_t        cur,
    output hba_pkg::hba_level_t        upd,
    output logic [hba_pkg::SMP_W-1:0]  half
);

    logic [2*hba_pkg::SMP_W-1:0] sq_reg;
    logic [2*hba_pkg::SMP_W-1:0] sq_next;
    logic [hba_pkg::SUM_W:0]     sum_wide;
    logic [hba_pkg::SQ_W:0]      sq_wide;
    logic [hba_pkg::SMP_W:0]     pair_sum;

    // signed square; never negative, fits the unsigned product width
    assign sq_next = 32'($signed(value) * $signed(value));

    always_ff @(posedge clk)
    begin
        if (sq_load)
        begin
            sq_reg <= sq_next;
        end
    end

    // saturating count
    assign upd.count = (cur.count == hba_pkg::CNT_MAX) ? cur.count : cur.count + 32'd1;

    // saturating signed sum, overflow seen in the top two bits
    assign sum_wide = {cur.sum[hba_pkg::SUM_W-1], cur.sum}
                    + {{(hba_pkg::SUM_W-hba_pkg::SMP_W+1){value[hba_pkg::SMP_W-1]}}, value};

    always_comb
    begin
        if (sum_wide[hba_pkg::SUM_W] != sum_wide[hba_pkg::SUM_W-1])
        begin
            upd.sum = sum_wide[hba_pkg::SUM_W] ? hba_pkg::SUM_MIN : hba_pkg::SUM_MAX;
        end
        else
        begin
            upd.sum = sum_wide[hba_pkg::SUM_W-1:0];
        end
    end

    // saturating square sum
    assign sq_wide = {1'b0, cur.sq} + {{(hba_pkg::SQ_W-2*hba_pkg::SMP_W+1){1'b0}}, sq_reg};
    assign upd.sq  = sq_wide[hba_pkg::SQ_W] ? hba_pkg::SQ_MAX : sq_wide[hba_pkg::SQ_W-1:0];

    // held fields pass through, the sequencer picks them
    assign upd.held       = cur.held;
    assign upd.held_valid = cur.held_valid;

    // floored half-sum of the held and incoming sample
    assign pair_sum = {cur.held[hba_pkg::SMP_W-1], cur.held}
                    + {value[hba_pkg::SMP_W-1], value};
    assign half     = pair_sum[hba_pkg::SMP_W:1];

endmodule

>>> hw/rtl/hierarchical_binning_accumulator.sv
// hierarchical binning accumulator: sequencer and output register
// add beat: S_FETCH then S_UPDATE for each level the carry cascade visits, then S_RESULT;
// read beat: S_FETCH then S_RESULT; S_RESULT waits while out_stall holds a pending result
// one item at a time: in_stall stays high until the result is registered, then the
// sequencer is back in S_IDLE and can accept the next item
// reset (rst_n, async) clears all levels and error_bars_off; needs hba_pkg, store, unit
module hierarchical_binning_accumulator #(
    parameter int LEVELS = hba_pkg::LEVELS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_we,
    input  logic                          cfg_wdata,
    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          op,
    input  logic [hba_pkg::SMP_W-1:0]     sample,
    input  logic [hba_pkg::LVL_IN_W-1:0]  level,
    // output channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [hba_pkg::CNT_W-1:0]     sample_count,
    output logic [hba_pkg::SUM_W-1:0]     value_sum,
    output logic [hba_pkg::SQ_W-1:0]      square_sum,
    output logic                          pending_flag,
    output logic [hba_pkg::DEPTH_W-1:0]   depth_reached
);

    localparam int LVW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int LXW = 6;
    localparam logic [LVW-1:0] LAST_LV = LVW'(LEVELS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_UPDATE,
        S_RESULT
    } state_t;

    state_t                    state_reg, state_next;
    logic                      op_reg, op_next;
    logic [hba_pkg::SMP_W-1:0] v_reg, v_next;
    logic                      lvl_ok_reg, lvl_ok_next;
    logic [LVW-1:0]            lv_reg, lv_next;
    logic [LXW-1:0]            depth_reg, depth_next;
    logic                      ebo_reg;

    logic                         out_valid_reg, out_valid_next;
    logic [hba_pkg::CNT_W-1:0]    cnt_out_reg, cnt_out_next;
    logic [hba_pkg::SUM_W-1:0]    sum_out_reg, sum_out_next;
    logic [hba_pkg::SQ_W-1:0]     sq_out_reg, sq_out_next;
    logic                         pend_out_reg, pend_out_next;
    logic [hba_pkg::DEPTH_W-1:0]  depth_out_reg, depth_out_next;

    logic [LXW-1:0]            lvl_ext;
    hba_pkg::hba_wr_ctl_t      wr_ctl;
    hba_pkg::hba_level_t       wdata;
    hba_pkg::hba_level_t       rdata;
    hba_pkg::hba_level_t       upd;
    logic [hba_pkg::SMP_W-1:0] half;
    logic                      in_beat;
    logic                      out_free;

    assign lvl_ext  = {{(LXW-hba_pkg::LVL_IN_W){1'b0}}, level};
    assign in_stall = (state_reg != S_IDLE);
    assign in_beat  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ebo_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            ebo_reg <= cfg_wdata;
        end
    end

    // level store and shared arithmetic
    hba_level_store #(
        .LEVELS (LEVELS),
        .LVW    (LVW)
    ) u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .addr   (lv_reg),
        .wr_ctl (wr_ctl),
        .wdata  (wdata),
        .rdata  (rdata)
    );

    hba_update_unit u_update (
        .clk     (clk),
        .sq_load (state_reg == S_FETCH),
        .value   (v_reg),
        .cur     (rdata),
        .upd     (upd),
        .half    (half)
    );

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        v_next         = v_reg;
        lvl_ok_next    = lvl_ok_reg;
        lv_next        = lv_reg;
        depth_next     = depth_reg;
        out_valid_next = out_valid_reg && out_stall;
        cnt_out_next   = cnt_out_reg;
        sum_out_next   = sum_out_reg;
        sq_out_next    = sq_out_reg;
        pend_out_next  = pend_out_reg;
        depth_out_next = depth_out_reg;
        wr_ctl         = '0;
        wdata          = upd;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    op_next     = op;
                    v_next      = sample;
                    lvl_ok_next = (lvl_ext < LXW'(LEVELS));
                    depth_next  = '0;
                    lv_next     = (op == hba_pkg::OP_READ) ? lvl_ext[LVW-1:0] : '0;
                    state_next  = S_FETCH;
                end
            end
            S_FETCH:
            begin
                state_next = (op_reg == hba_pkg::OP_READ) ? S_RESULT : S_UPDATE;
            end
            S_UPDATE:
            begin
                wr_ctl.stats_we = 1'b1;
                depth_next      = depth_reg + LXW'(1);
                if (ebo_reg)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    wr_ctl.sq_we   = 1'b1;
                    wr_ctl.held_we = 1'b1;
                    if (rdata.held_valid)
                    begin
                        // pair complete: carry the half-sum up, drop it past the last level
                        wdata.held_valid = 1'b0;
                        v_next           = half;
                        if (lv_reg == LAST_LV)
                        begin
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            lv_next    = lv_reg + LVW'(1);
                            state_next = S_FETCH;
                        end
                    end
                    else
                    begin
                        wdata.held       = v_reg;
                        wdata.held_valid = 1'b1;
                        state_next       = S_RESULT;
                    end
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (op_reg == hba_pkg::OP_READ && lvl_ok_reg)
                    begin
                        cnt_out_next  = rdata.count;
                        sum_out_next  = rdata.sum;
                        sq_out_next   = rdata.sq;
                        pend_out_next = rdata.held_valid;
                    end
                    else
                    begin
                        cnt_out_next  = '0;
                        sum_out_next  = '0;
                        sq_out_next   = '0;
                        pend_out_next = 1'b0;
                    end
                    depth_out_next = (op_reg == hba_pkg::OP_READ) ? '0
                                                                  : depth_reg[hba_pkg::DEPTH_W-1:0];
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= hba_pkg::OP_ADD;
            v_reg         <= '0;
            lvl_ok_reg    <= 1'b0;
            lv_reg        <= '0;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
            cnt_out_reg   <= '0;
            sum_out_reg   <= '0;
            sq_out_reg    <= '0;
            pend_out_reg  <= 1'b0;
            depth_out_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            v_reg         <= v_next;
            lvl_ok_reg    <= lvl_ok_next;
            lv_reg        <= lv_next;
            depth_reg     <= depth_next;
            out_valid_reg <= out_valid_next;
            cnt_out_reg   <= cnt_out_next;
            sum_out_reg   <= sum_out_next;
            sq_out_reg    <= sq_out_next;
            pend_out_reg  <= pend_out_next;
            depth_out_reg <= depth_out_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign sample_count  = cnt_out_reg;
    assign value_sum     = sum_out_reg;
    assign square_sum    = sq_out_reg;
    assign pending_flag  = pend_out_reg;
    assign depth_reached = depth_out_reg;

endmodule
